// ===== rtl/fcrt_pkg.sv =====
// fcrt_pkg: shared types and constants of the frame chunk reassembly tracker
// used by fcrt_offset_table and frame_chunk_reassembly_tracker_unit
package fcrt_pkg;

   localparam int unsigned TableDepth = 128;
   localparam int unsigned TableAw    = $clog2(TableDepth);
   localparam int unsigned CountW     = TableAw + 1;
   localparam int unsigned OffW       = 21;
   localparam logic [31:0] MagicWord  = 32'h4D564631;
   localparam logic [15:0] HeaderBytes = 16'd16;

   typedef enum logic [1:0] {
      OP_HEADER  = 2'd0,
      OP_TAKE    = 2'd1,
      OP_FLIP    = 2'd2,
      OP_VERDICT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_PLACED = 3'd0,
      ST_SHORT  = 3'd1,
      ST_MAGIC  = 3'd2,
      ST_FLIP   = 3'd3,
      ST_BOUNDS = 3'd4,
      ST_STALE  = 3'd5,
      ST_DUP    = 3'd6,
      ST_POLL   = 3'd7
   } status_type;

   localparam logic CSR_FRAME_BYTES = 1'b0;
   localparam logic CSR_COMPRESSED  = 1'b1;

   // search request from the control unit to the offset table
   typedef struct packed {
      logic              start;
      logic [OffW-1:0]   offset;
      logic [CountW-1:0] count;
   } scan_req_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_rsp_type;

endpackage

// ===== rtl/fcrt_offset_table.sv =====
// fcrt_offset_table: memory of seen chunk offsets with a sequential search
// depends on fcrt_pkg
module fcrt_offset_table (
   input  logic                               clock,
   input  logic                               reset,
   input  fcrt_pkg::scan_req_type             scan_req,
   output fcrt_pkg::scan_rsp_type             scan_rsp,
   input  logic                               wr_en,
   input  logic [fcrt_pkg::TableAw-1:0]       wr_addr,
   input  logic [fcrt_pkg::OffW-1:0]          wr_data
);

   logic [fcrt_pkg::OffW-1:0] mem [fcrt_pkg::TableDepth];
   logic [fcrt_pkg::OffW-1:0] rd_data_ff;
   logic [fcrt_pkg::CountW-1:0] idx_ff, idx_in;
   logic [fcrt_pkg::OffW-1:0] key_ff;
   logic [fcrt_pkg::CountW-1:0] cnt_ff;
   logic busy_ff, busy_in, chk_ff, chk_in;
   logic done_in, found_in;
   logic [fcrt_pkg::TableAw-1:0] rd_addr;

   assign rd_addr = idx_ff[fcrt_pkg::TableAw-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // one address issued per cycle, compared in the cycle after
   always_comb begin
      busy_in  = busy_ff;
      chk_in   = 1'b0;
      idx_in   = idx_ff;
      done_in  = 1'b0;
      found_in = 1'b0;
      if (chk_ff && rd_data_ff == key_ff) begin
         done_in  = 1'b1;
         found_in = 1'b1;
         busy_in  = 1'b0;
      end else if (busy_ff) begin
         if (idx_ff < cnt_ff) begin
            chk_in = 1'b1;
            idx_in = idx_ff + 1'b1;
         end else if (!chk_ff) begin
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
      if (scan_req.start) begin
         busy_in = 1'b1;
         chk_in  = 1'b0;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chk_ff  <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         chk_ff  <= chk_in;
         idx_ff  <= idx_in;
      end
      if (scan_req.start) begin
         key_ff <= scan_req.offset;
         cnt_ff <= scan_req.count;
      end
   end

   assign scan_rsp.done  = done_in;
   assign scan_rsp.found = found_in;

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      scan_rsp.found |-> scan_rsp.done) else $error("found without done");
   a_chk_busy: assert property (@(posedge clock) disable iff (reset)
      chk_ff |-> $past(busy_ff)) else $error("compare outside a search");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= cnt_ff) else $error("search index beyond count");

endmodule

// ===== rtl/frame_chunk_reassembly_tracker_unit.sv =====
// frame_chunk_reassembly_tracker_unit: top level of the reassembly tracker
// depends on fcrt_pkg and fcrt_offset_table
//
// channel | direction | payload
// req_    | in        | tuser: op
//         |           | tdata: datagram_len, magic, frame_tag, flags, total_len,
//         |           |        chunk_offset, decomp_ok
// rsp_    | out       | tuser: status
//         |           | tdata: write_enable, write_offset, length, to_scratch,
//         |           |        decompress_start, answer, four counters
// csr_    | in        | write enable, register index, 21-bit data
//
// one transaction at a time; polls, verdicts and refused headers go from idle straight
// to the result register, a header that reaches the duplicate search also passes
// through S_SCAN, which reads the n offsets stored for the frame (at most 128) one
// by one through the single memory read port
// reset clears all control state; the offset memory needs no clearing pass
// req_tready stays low while a transaction is in work or its result waits
module frame_chunk_reassembly_tracker_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   // datagram_len[15:0] magic[47:16] frame_tag[63:48] flags[79:64]
   // total_len[111:80] chunk_offset[143:112] decomp_ok[144], zero fill
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0]
   output logic [2:0]   rsp_tuser,
   // write_enable[0] write_offset[21:1] length[42:22] to_scratch[43]
   // decompress_start[44] answer[45] frames_count[77:46] dropped_count[109:78]
   // flip_ok_count[141:110] flip_gated_count[173:142], zero fill
   output logic [175:0] rsp_tdata,
   input  logic         csr_wen,
   input  logic         csr_index,
   input  logic [20:0]  csr_wdata
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_type;
   state_type state_ff;

   // configuration
   logic [20:0] frame_bytes_ff;
   logic        comp_en_ff;

   // tracker state
   logic [15:0] current_id_ff, last_done_id_ff;
   logic in_prog_ff, have_done_ff, cur_comp_ff, ready_ff, flip_pend_ff;
   logic back_comp_ff, decomp_pend_ff;
   logic [fcrt_pkg::CountW-1:0] seen_cnt_ff;
   logic [31:0] bytes_ff;
   logic [31:0] frames_ff, dropped_ff, flip_ok_ff, flip_gated_ff;

   // held header fields during the search
   logic [20:0] h_off_ff, h_clen_ff, h_total21_ff;
   logic [31:0] h_total_ff;

   // result register
   logic [2:0]  r_status_ff;
   logic        r_we_ff, r_scr_ff, r_ds_ff, r_ans_ff;
   logic [20:0] r_woff_ff, r_len_ff;

   // input unpacking
   logic [1:0]  i_op;
   logic [15:0] i_dlen, i_fid, i_flags;
   logic [31:0] i_magic, i_total, i_off;
   logic        i_ok;
   assign i_op    = req_tuser;
   assign i_dlen  = req_tdata[15:0];
   assign i_magic = req_tdata[47:16];
   assign i_fid   = req_tdata[63:48];
   assign i_flags = req_tdata[79:64];
   assign i_total = req_tdata[111:80];
   assign i_off   = req_tdata[143:112];
   assign i_ok    = req_tdata[144];

   logic accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // header checks
   logic [15:0] clen16;
   logic [32:0] end33;
   logic        packed_h, bad_bounds, stale, new_frame;
   assign clen16   = i_dlen - fcrt_pkg::HeaderBytes;
   assign end33    = {1'b0, i_off} + {17'd0, clen16};
   assign packed_h = i_flags[1];
   always_comb begin
      if (packed_h)
         bad_bounds = !comp_en_ff || i_total == 32'd0
                      || i_total > {11'd0, frame_bytes_ff} || end33 > {1'b0, i_total};
      else
         bad_bounds = i_total != {11'd0, frame_bytes_ff}
                      || end33 > {12'd0, frame_bytes_ff};
   end
   assign stale     = have_done_ff && i_fid == last_done_id_ff;
   assign new_frame = i_fid != current_id_ff || !in_prog_ff;

   // duplicate search: the stored offsets are 21 bits, so an offset with high
   // bits set never matches
   fcrt_pkg::scan_req_type scan_req;
   fcrt_pkg::scan_rsp_type scan_rsp;
   logic wr_en;
   logic hi_zero_ff;

   fcrt_offset_table u_table (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp),
      .wr_en    (wr_en),
      .wr_addr  (seen_cnt_ff[fcrt_pkg::TableAw-1:0]),
      .wr_data  (h_off_ff)
   );

   logic go_scan;
   assign go_scan = accept && i_op == fcrt_pkg::OP_HEADER
                    && i_dlen >= fcrt_pkg::HeaderBytes && i_magic == fcrt_pkg::MagicWord
                    && !i_flags[0] && !bad_bounds && !stale;
   assign scan_req.start  = go_scan;
   assign scan_req.offset = i_off[20:0];
   assign scan_req.count  = new_frame ? '0 : seen_cnt_ff;

   logic placed;
   assign placed = state_ff == S_SCAN && scan_rsp.done && !(scan_rsp.found && hi_zero_ff);
   assign wr_en  = placed && seen_cnt_ff < fcrt_pkg::CountW'(fcrt_pkg::TableDepth);

   logic [31:0] bytes_sum;
   assign bytes_sum = bytes_ff + {11'd0, h_clen_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         frame_bytes_ff <= 21'd4096;
         comp_en_ff <= 1'b1;
         current_id_ff <= '0; last_done_id_ff <= '0;
         in_prog_ff <= 1'b0; have_done_ff <= 1'b0; cur_comp_ff <= 1'b0;
         ready_ff <= 1'b0; flip_pend_ff <= 1'b0; back_comp_ff <= 1'b0;
         decomp_pend_ff <= 1'b0; seen_cnt_ff <= '0; bytes_ff <= '0;
         frames_ff <= '0; dropped_ff <= '0; flip_ok_ff <= '0; flip_gated_ff <= '0;
      end else begin
         if (csr_wen) begin
            if (csr_index == fcrt_pkg::CSR_FRAME_BYTES) frame_bytes_ff <= csr_wdata;
            else comp_en_ff <= csr_wdata[0];
         end
         unique case (state_ff)
            S_IDLE: if (accept) begin
               r_status_ff <= fcrt_pkg::ST_POLL;
               r_we_ff <= 1'b0; r_woff_ff <= '0; r_len_ff <= '0;
               r_scr_ff <= 1'b0; r_ds_ff <= 1'b0; r_ans_ff <= 1'b0;
               state_ff <= S_OUT;
               unique case (i_op)
                  fcrt_pkg::OP_HEADER: begin
                     if (i_dlen < fcrt_pkg::HeaderBytes) r_status_ff <= fcrt_pkg::ST_SHORT;
                     else if (i_magic != fcrt_pkg::MagicWord)
                        r_status_ff <= fcrt_pkg::ST_MAGIC;
                     else if (i_flags[0]) begin
                        r_status_ff <= fcrt_pkg::ST_FLIP;
                        flip_pend_ff <= 1'b1;
                     end else if (bad_bounds) r_status_ff <= fcrt_pkg::ST_BOUNDS;
                     else if (stale) r_status_ff <= fcrt_pkg::ST_STALE;
                     else begin
                        if (new_frame) begin
                           if (in_prog_ff) dropped_ff <= dropped_ff + 32'd1;
                           current_id_ff <= i_fid; in_prog_ff <= 1'b1;
                           bytes_ff <= '0; seen_cnt_ff <= '0;
                           cur_comp_ff <= packed_h; back_comp_ff <= 1'b0;
                           decomp_pend_ff <= 1'b0;
                        end
                        h_off_ff <= i_off[20:0];
                        hi_zero_ff <= i_off[31:21] == 11'd0;
                        h_clen_ff <= {5'd0, clen16};
                        h_total_ff <= i_total;
                        h_total21_ff <= i_total[20:0];
                        state_ff <= S_SCAN;
                     end
                  end
                  fcrt_pkg::OP_TAKE: begin
                     r_ans_ff <= ready_ff;
                     ready_ff <= 1'b0;
                  end
                  fcrt_pkg::OP_FLIP: if (flip_pend_ff) begin
                     flip_pend_ff <= 1'b0;
                     if (!back_comp_ff) flip_gated_ff <= flip_gated_ff + 32'd1;
                     else begin
                        flip_ok_ff <= flip_ok_ff + 32'd1;
                        back_comp_ff <= 1'b0;
                        r_ans_ff <= 1'b1;
                     end
                  end
                  fcrt_pkg::OP_VERDICT: if (decomp_pend_ff) begin
                     decomp_pend_ff <= 1'b0;
                     if (i_ok) begin
                        ready_ff <= 1'b1; back_comp_ff <= 1'b1;
                        frames_ff <= frames_ff + 32'd1;
                        r_ans_ff <= 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            S_SCAN: if (scan_rsp.done) begin
               state_ff <= S_OUT;
               if (!placed) r_status_ff <= fcrt_pkg::ST_DUP;
               else begin
                  r_status_ff <= fcrt_pkg::ST_PLACED;
                  if (wr_en) seen_cnt_ff <= seen_cnt_ff + 1'b1;
                  r_we_ff <= 1'b1; r_woff_ff <= h_off_ff;
                  r_len_ff <= h_clen_ff; r_scr_ff <= cur_comp_ff;
                  bytes_ff <= bytes_sum;
                  if (bytes_sum >= h_total_ff) begin
                     in_prog_ff <= 1'b0;
                     last_done_id_ff <= current_id_ff;
                     have_done_ff <= 1'b1;
                     if (cur_comp_ff) begin
                        decomp_pend_ff <= 1'b1;
                        r_ds_ff <= 1'b1;
                        r_len_ff <= h_total21_ff;
                     end else begin
                        ready_ff <= 1'b1; back_comp_ff <= 1'b1;
                        frames_ff <= frames_ff + 32'd1;
                     end
                  end
               end
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = state_ff == S_OUT;
   assign rsp_tuser  = r_status_ff;
   assign rsp_tdata  = {2'd0, flip_gated_ff, flip_ok_ff, dropped_ff, frames_ff,
                        r_ans_ff, r_ds_ff, r_scr_ff, r_len_ff, r_woff_ff, r_we_ff};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("input taken with result waiting");
   a_write_placed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r_we_ff |-> r_status_ff == fcrt_pkg::ST_PLACED)
      else $error("write without placed status");
   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      seen_cnt_ff <= fcrt_pkg::CountW'(fcrt_pkg::TableDepth))
      else $error("offset count overflow");

endmodule

// ===== dv/frame_chunk_reassembly_tracker_unit_test.sv =====
// testbench of frame_chunk_reassembly_tracker_unit: directed and random datagram streams
// with a scoreboard class that predicts every result; depends on fcrt_pkg and the rtl
module frame_chunk_reassembly_tracker_unit_test;

   // result layout, lowest field last; status comes from tuser
   typedef struct packed {
      logic [1:0]  pad;
      logic [31:0] gated_cnt;
      logic [31:0] flip_ok_cnt;
      logic [31:0] dropped_cnt;
      logic [31:0] frames_cnt;
      logic        answer;
      logic        decomp_start;
      logic        to_scratch;
      logic [20:0] length;
      logic [20:0] wr_offset;
      logic        wr_en;
      fcrt_pkg::status_type status;
   } chunk_result_type;

   class reassembly_scoreboard;
      logic [20:0]   frame_size;
      logic          packed_allowed;
      logic [15:0]   cur_id;
      logic          busy;
      logic [15:0]   done_id;
      logic          done_valid;
      logic          cur_packed;
      logic [20:0]   offsets_seen [fcrt_pkg::TableDepth];
      int unsigned   seen_n;
      logic [31:0]   byte_sum;
      logic          ready_flag;
      logic          flip_req;
      logic          back_full;
      logic          verdict_wait;
      logic [31:0]   n_frames, n_dropped, n_flip_ok, n_gated;
      chunk_result_type pending_results [$];
      int unsigned   errors;

      function new();
         frame_size = 21'd4096;
         packed_allowed = 1'b1;
         cur_id = '0; busy = 0; done_id = '0; done_valid = 0; cur_packed = 0;
         seen_n = 0; byte_sum = '0; ready_flag = 0; flip_req = 0; back_full = 0;
         verdict_wait = 0;
         n_frames = '0; n_dropped = '0; n_flip_ok = '0; n_gated = '0;
         errors = 0;
      endfunction

      function void write_reg(logic idx, logic [20:0] val);
         if (idx == fcrt_pkg::CSR_FRAME_BYTES) frame_size = val;
         else packed_allowed = val[0];
      endfunction

      // header path; fills the write fields of r and returns the status
      function fcrt_pkg::status_type place_chunk(logic [151:0] d, ref chunk_result_type r);
         logic [15:0]     dlen;
         logic [31:0]     magic;
         logic [15:0]     fid;
         logic [15:0]     flg;
         longint unsigned total, off, clen;
         logic            pk;
         dlen  = d[15:0];
         magic = d[47:16];
         fid   = d[63:48];
         flg   = d[79:64];
         total = d[111:80];
         off   = d[143:112];
         if (dlen < fcrt_pkg::HeaderBytes) return fcrt_pkg::ST_SHORT;
         if (magic != fcrt_pkg::MagicWord) return fcrt_pkg::ST_MAGIC;
         if (flg[0]) begin
            flip_req = 1;
            return fcrt_pkg::ST_FLIP;
         end
         pk = flg[1];
         clen = dlen - 16;
         if (pk) begin
            if (!packed_allowed || total == 0 || total > frame_size || off + clen > total)
               return fcrt_pkg::ST_BOUNDS;
         end else begin
            if (total != frame_size || off + clen > frame_size) return fcrt_pkg::ST_BOUNDS;
         end
         if (done_valid && fid == done_id) return fcrt_pkg::ST_STALE;
         if (fid != cur_id || !busy) begin
            if (busy) n_dropped++;
            cur_id = fid; busy = 1; byte_sum = '0; seen_n = 0;
            cur_packed = pk; back_full = 0; verdict_wait = 0;
         end
         for (int i = 0; i < seen_n; i++)
            if ({11'd0, offsets_seen[i]} == off[31:0]) return fcrt_pkg::ST_DUP;
         if (seen_n < fcrt_pkg::TableDepth) begin
            offsets_seen[seen_n] = off[20:0];
            seen_n++;
         end
         r.wr_en = 1;
         r.wr_offset = off[20:0];
         r.length = clen[20:0];
         r.to_scratch = cur_packed;
         byte_sum = byte_sum + clen[31:0];
         if ({32'd0, byte_sum} >= total) begin
            busy = 0; done_id = cur_id; done_valid = 1;
            if (cur_packed) begin
               verdict_wait = 1;
               r.decomp_start = 1;
               r.length = total[20:0];
            end else begin
               ready_flag = 1; back_full = 1; n_frames++;
            end
         end
         return fcrt_pkg::ST_PLACED;
      endfunction

      // accepted request transaction: work out its result
      function void note_request(logic [1:0] op, logic [151:0] d);
         chunk_result_type r;
         r = '0;
         r.status = fcrt_pkg::ST_POLL;
         case (fcrt_pkg::op_type'(op))
            fcrt_pkg::OP_HEADER: r.status = place_chunk(d, r);
            fcrt_pkg::OP_TAKE: begin
               r.answer = ready_flag;
               ready_flag = 0;
            end
            fcrt_pkg::OP_FLIP: begin
               if (flip_req) begin
                  flip_req = 0;
                  if (!back_full) n_gated++;
                  else begin
                     n_flip_ok++; back_full = 0; r.answer = 1;
                  end
               end
            end
            default: begin
               if (verdict_wait) begin
                  verdict_wait = 0;
                  if (d[144]) begin
                     ready_flag = 1; back_full = 1; n_frames++; r.answer = 1;
                  end
               end
            end
         endcase
         r.frames_cnt = n_frames;
         r.dropped_cnt = n_dropped;
         r.flip_ok_cnt = n_flip_ok;
         r.gated_cnt = n_gated;
         pending_results.push_back(r);
      endfunction

      function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            errors++;
            $display("%0t %s expected %0h actual %0h", $time, name, e, a);
         end
      endfunction

      // accepted result transaction against the oldest prediction
      function void check_result(chunk_result_type a);
         chunk_result_type e;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t unexpected result expected none actual %h", $time, a);
            return;
         end
         e = pending_results.pop_front();
         cmp_field("status", e.status, a.status);
         cmp_field("write_enable", e.wr_en, a.wr_en);
         cmp_field("write_offset", e.wr_offset, a.wr_offset);
         cmp_field("length", e.length, a.length);
         cmp_field("to_scratch", e.to_scratch, a.to_scratch);
         cmp_field("decompress_start", e.decomp_start, a.decomp_start);
         cmp_field("answer", e.answer, a.answer);
         cmp_field("frames_count", e.frames_cnt, a.frames_cnt);
         cmp_field("dropped_count", e.dropped_cnt, a.dropped_cnt);
         cmp_field("flip_ok_count", e.flip_ok_cnt, a.flip_ok_cnt);
         cmp_field("flip_gated_count", e.gated_cnt, a.gated_cnt);
         cmp_field("fill", e.pad, a.pad);
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [151:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [2:0]   rsp_tuser;
   logic [175:0] rsp_tdata;
   logic         csr_wen = 0;
   logic         csr_index = 0;
   logic [20:0]  csr_wdata = '0;

   reassembly_scoreboard sb = new();
   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   int unsigned items_sent = 0;
   logic [20:0] cur_fb = 21'd4096;
   logic        cur_ce = 1'b1;

   frame_chunk_reassembly_tracker_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // generous ceiling on the whole run
   initial begin
      #(8 * 3000000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // both handshakes observed with pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(chunk_result_type'({rsp_tdata, rsp_tuser}));
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   function automatic logic [151:0] pack_req(logic [15:0] dlen,
         logic [31:0] magic, logic [15:0] fid, logic [15:0] flg, logic [31:0] total,
         logic [31:0] off, logic ok);
      return {7'd0, ok, off, total, flg, fid, magic, dlen};
   endfunction

   // one request transaction, idling cycle by cycle before it
   task automatic send_item(fcrt_pkg::op_type op, logic [151:0] d);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_hdr(logic [15:0] dlen, logic [31:0] magic, logic [15:0] fid,
         logic [15:0] flg, logic [31:0] total, logic [31:0] off);
      send_item(fcrt_pkg::OP_HEADER,
                pack_req(dlen, magic, fid, flg, total, off, 1'($urandom_range(0, 1))));
   endtask

   task automatic send_op(fcrt_pkg::op_type op, logic ok);
      send_item(op, pack_req(16'($urandom), $urandom, 16'($urandom), 16'($urandom),
                             $urandom, $urandom, ok));
   endtask

   // sender pause until every predicted result has been checked
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [20:0] val);
      csr_wen   <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 0;
      sb.write_reg(idx, val);
      if (idx == fcrt_pkg::CSR_FRAME_BYTES) cur_fb = val;
      else cur_ce = val[0];
      @(posedge clock);
   endtask

   // one frame as shuffled chunks, with stray repeats, polls and abandonment
   task automatic send_frame(logic pk, logic tiny_chunks);
      longint unsigned total, cs, lo, hi, o;
      logic [31:0]     offs [$];
      int unsigned     lens [$];
      logic [15:0]     fid, flg;
      int unsigned     j, t;
      logic [31:0]     tmp_o;
      int unsigned     tmp_l;
      total = pk ? $urandom_range(1, (cur_fb == 0) ? 1 : cur_fb) : cur_fb;
      fid = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) == 0) fid = sb.done_id;
      flg = pk ? 16'h0002 : 16'h0000;
      if ($urandom_range(0, 3) == 0) flg = flg | (16'($urandom) & 16'hFFFC);
      if (total == 0) begin
         offs.push_back(0);
         lens.push_back(0);
      end else begin
         hi = (total > 65519) ? 65519 : total;
         lo = total / 40 + 1;
         if (lo > hi) lo = hi;
         cs = tiny_chunks ? 16 : $urandom_range(32'(lo), 32'(hi));
         for (o = 0; o < total; o += cs) begin
            offs.push_back(32'(o));
            lens.push_back(32'((total - o < cs) ? total - o : cs));
         end
      end
      for (int i = offs.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp_o = offs[i]; offs[i] = offs[j]; offs[j] = tmp_o;
         tmp_l = lens[i]; lens[i] = lens[j]; lens[j] = tmp_l;
      end
      for (int i = 0; i < offs.size(); i++) begin
         if ($urandom_range(0, 39) == 0) break;
         send_hdr(16'(lens[i] + 16), fcrt_pkg::MagicWord, fid, flg, 32'(total), offs[i]);
         if ($urandom_range(0, 9) == 0)
            send_hdr(16'(lens[i] + 16), fcrt_pkg::MagicWord, fid, flg, 32'(total), offs[i]);
         if ($urandom_range(0, 14) == 0)
            send_op($urandom_range(0, 1) ? fcrt_pkg::OP_TAKE : fcrt_pkg::OP_FLIP,
                    1'($urandom_range(0, 1)));
      end
      // past the table limit, one of the first offsets sent is sent again
      if (tiny_chunks) begin
         t = $urandom_range(0, (offs.size() > 8) ? 7 : offs.size() - 1);
         send_hdr(16'(lens[t] + 16), fcrt_pkg::MagicWord, fid, flg, 32'(total), offs[t]);
      end
      if (pk && $urandom_range(0, 4) != 0)
         send_op(fcrt_pkg::OP_VERDICT, $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) send_op(fcrt_pkg::OP_TAKE, 0);
      if ($urandom_range(0, 1)) begin
         send_hdr(16'(16 + $urandom_range(0, 100)), fcrt_pkg::MagicWord, 16'($urandom),
                  16'h0001 | 16'($urandom), $urandom, $urandom);
         send_op(fcrt_pkg::OP_FLIP, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 5) == 0 && offs.size() != 0)
         send_hdr(16'(lens[0] + 16), fcrt_pkg::MagicWord, fid, flg, 32'(total), offs[0]);
   endtask

   // anything at all, good magic now and then
   task automatic send_noise();
      logic [31:0] m;
      m = $urandom_range(0, 1) ? fcrt_pkg::MagicWord : $urandom;
      if ($urandom_range(0, 1))
         send_item(fcrt_pkg::op_type'($urandom_range(0, 3)),
                   pack_req(16'($urandom), m, 16'($urandom), 16'($urandom),
                            $urandom, $urandom, 1'($urandom_range(0, 1))));
      else
         send_hdr(16'($urandom_range(0, 40)), m, 16'($urandom), 16'($urandom) & 16'h0002,
                  $urandom_range(0, 64), $urandom_range(0, 64));
   endtask

   task automatic random_phase(int unsigned quota);
      int unsigned stop_at;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7)
            send_frame($urandom_range(0, 2) == 0,
                       cur_fb == 4096 && $urandom_range(0, 14) == 0);
         else
            send_noise();
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed part, sender idling little and receiver much
      tx_idle_pct = 12; rx_idle_pct = 85;
      write_csr(fcrt_pkg::CSR_FRAME_BYTES, 21'd16);
      write_csr(fcrt_pkg::CSR_COMPRESSED, 21'd1);
      send_hdr(16'd15, fcrt_pkg::MagicWord, 16'd1, 16'h0000, 32'd16, 32'd0); // short
      send_hdr(16'd0, fcrt_pkg::MagicWord, 16'd1, 16'h0000, 32'd16, 32'd0);
      send_hdr(16'd24, 32'h0, 16'd1, 16'h0000, 32'd16, 32'd0);        // bad magic
      send_hdr(16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_hdr(16'd20, fcrt_pkg::MagicWord, 16'd3, 16'hFFFF, 32'd0, 32'd0); // flip header
      send_op(fcrt_pkg::OP_FLIP, 0);                                  // gated flip
      send_op(fcrt_pkg::OP_TAKE, 0);
      send_op(fcrt_pkg::OP_VERDICT, 1);                               // verdict, no request
      send_hdr(16'd24, fcrt_pkg::MagicWord, 16'd5, 16'h0000, 32'd17, 32'd0); // size mismatch
      send_hdr(16'd24, fcrt_pkg::MagicWord, 16'd5, 16'h0000, 32'd16, 32'hFFFFFFFF);
      send_hdr(16'd24, fcrt_pkg::MagicWord, 16'd5, 16'h0000, 32'd16, 32'd0);
      send_hdr(16'd24, fcrt_pkg::MagicWord, 16'd5, 16'h0000, 32'd16, 32'd0); // duplicate
      send_hdr(16'd24, fcrt_pkg::MagicWord, 16'd5, 16'h0000, 32'd16, 32'd8); // completes
      send_hdr(16'd24, fcrt_pkg::MagicWord, 16'd5, 16'h0000, 32'd16, 32'd0); // stale copy
      send_op(fcrt_pkg::OP_TAKE, 0);
      send_hdr(16'd16, fcrt_pkg::MagicWord, 16'd5, 16'h0001, 32'd0, 32'd0);
      send_op(fcrt_pkg::OP_FLIP, 0);                                  // presented flip
      send_hdr(16'd26, fcrt_pkg::MagicWord, 16'd7, 16'h0002, 32'd10, 32'd0); // blob complete
      send_op(fcrt_pkg::OP_VERDICT, 1);
      send_hdr(16'd20, fcrt_pkg::MagicWord, 16'd8, 16'h0002, 32'd0, 32'd0);  // zero blob size
      send_hdr(16'd20, fcrt_pkg::MagicWord, 16'd8, 16'h0002, 32'd17, 32'd0); // over capacity
      send_hdr(16'd20, fcrt_pkg::MagicWord, 16'd8, 16'h0002, 32'd16, 32'd0); // partial blob
      send_hdr(16'd20, fcrt_pkg::MagicWord, 16'd8, 16'h0000, 32'd16, 32'd4); // mixed type
      send_hdr(16'd20, fcrt_pkg::MagicWord, 16'd9, 16'h0000, 32'd16, 32'd0); // drops frame
      send_op(fcrt_pkg::OP_VERDICT, 1);
      drain();
      write_csr(fcrt_pkg::CSR_COMPRESSED, 21'd0);
      write_csr(fcrt_pkg::CSR_FRAME_BYTES, 21'd0);
      send_hdr(16'd16, fcrt_pkg::MagicWord, 16'd11, 16'h0000, 32'd0, 32'd0); // empty frame
      send_hdr(16'd20, fcrt_pkg::MagicWord, 16'd12, 16'h0002, 32'd4, 32'd0); // refused
      drain();

      // random part in five phases under three idling settings
      tx_idle_pct = 12; rx_idle_pct = 85;
      write_csr(fcrt_pkg::CSR_FRAME_BYTES, 21'd4096);
      write_csr(fcrt_pkg::CSR_COMPRESSED, 21'd1);
      random_phase(450);
      tx_idle_pct = 85; rx_idle_pct = 12;
      write_csr(fcrt_pkg::CSR_FRAME_BYTES, 21'd1048576);
      write_csr(fcrt_pkg::CSR_COMPRESSED, 21'd0);
      random_phase(200);
      write_csr(fcrt_pkg::CSR_FRAME_BYTES, 21'd1);
      write_csr(fcrt_pkg::CSR_COMPRESSED, 21'd1);
      random_phase(200);
      tx_idle_pct = 0; rx_idle_pct = 0;
      write_csr(fcrt_pkg::CSR_FRAME_BYTES, 21'($urandom_range(2, 300)));
      random_phase(250);
      write_csr(fcrt_pkg::CSR_FRAME_BYTES, 21'd1048576);
      write_csr(fcrt_pkg::CSR_COMPRESSED, 21'd1);
      random_phase(200);

      // drain already waited for every result; allow a little more for strays
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
